/* rtl/core/rletd_pkg.sv */
`default_nettype none
package rletd_pkg;

	localparam int unsigned SCREEN_COLUMNS = 32;

	localparam int unsigned CFG_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned ROW_W     = 10;
	localparam int unsigned OFFSET_W  = 16;

	localparam logic [7:0]          TILE_MARK   = 8'h80;
	localparam logic [OFFSET_W-1:0] ROW_STEP    = OFFSET_W'(SCREEN_COLUMNS);
	localparam logic [ROW_W-1:0]    SCR_COLS_RW = ROW_W'(SCREEN_COLUMNS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X        = 3'd0,
		REG_ORIGIN_Y        = 3'd1,
		REG_IMAGE_WIDTH     = 3'd2,
		REG_IMAGE_HEIGHT    = 3'd3,
		REG_WINDOW_LAST_ROW = 3'd4
	} cfg_reg_e;

	typedef enum logic [1:0] {
		ST_TILE     = 2'd0,
		ST_BYTE     = 2'd1,
		ST_IDLE     = 2'd2,
		ST_FINISHED = 2'd3
	} status_e;

	typedef struct packed {
		logic       req_type;
		logic [7:0] stream_byte;
	} in_item_t;

	typedef struct packed {
		status_e             status;
		logic                write_enable;
		logic [OFFSET_W-1:0] screen_offset;
		logic [7:0]          tile_value;
		logic                last;
	} out_item_t;

endpackage
`default_nettype wire

/* rtl/core/rle_tile_decoder_with_clipping.sv */
// channel   direction  payload     handshake
// in        input      in_item_t   in_valid / in_stall
// out       output     out_item_t  out_valid / out_stall
// cfg       input      index+data  cfg_we, no wait
//
// One item per cycle while in_stall is low; each accepted item yields one result.
// Decode state updates in the same cycle the input transfer completes.
// A two-entry output stage (result register plus skid) holds one extra result
// while out_stall is high; in_stall rises only when both entries hold results.
// arst_n clears state to the image start for origin 0, size 1x1.
`default_nettype none
module rle_tile_decoder_with_clipping (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire rletd_pkg::in_item_t             in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output rletd_pkg::out_item_t                 out_data,
	input  wire logic                            cfg_we,
	input  wire logic [rletd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rletd_pkg::CFG_W-1:0]     cfg_data
);
	import rletd_pkg::*;

	logic      accept;
	logic      skid_full;
	out_item_t result;

	assign in_stall = skid_full;
	assign accept   = in_valid && !skid_full;

	rletd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	rletd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* rtl/core/rletd_skid.sv */
`default_nettype none
module rletd_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rletd_pkg::out_item_t push_data,
	output logic                      full,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output rletd_pkg::out_item_t      out_data
);
	import rletd_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	out_item_t out_data_q;
	out_item_t skid_data_q;
	logic      out_load;

	// output register may take a new entry when empty or when its transfer completes
	assign out_load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

/* rtl/core/rletd_core.sv */
`default_nettype none
module rletd_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire rletd_pkg::in_item_t             item,
	input  wire logic                            cfg_we,
	input  wire logic [rletd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rletd_pkg::CFG_W-1:0]     cfg_data,
	output rletd_pkg::out_item_t                 result
);
	import rletd_pkg::*;

	// configuration
	logic [7:0] ox_q, oy_q, width_q, height_q, wlr_q;
	logic [7:0] ox_n, oy_n, width_n, height_n, wlr_n;
	logic       restart;

	// decode and placement state
	logic [7:0]          held_q, run_q, col_q, rows_q;
	logic                await_q, in_win_q, fin_q;
	logic [ROW_W-1:0]    row_q;
	logic [OFFSET_W-1:0] rb_q, wp_q;

	logic [7:0]          held_n, run_n, col_n, rows_n;
	logic                await_n, in_win_n, fin_n;
	logic [ROW_W-1:0]    row_n;
	logic [OFFSET_W-1:0] rb_n, wp_n;

	// image start values
	logic [ROW_W-1:0]    row0;
	logic [OFFSET_W-1:0] rb0;
	logic                fin0;

	logic                do_emit;
	logic [7:0]          tile_src;
	logic [ROW_W-1:0]    col_pos;
	logic                tile_we;
	logic [7:0]          col_inc;
	logic [7:0]          rows_inc;
	logic [ROW_W-1:0]    row_inc;

	always_comb begin
		ox_n     = ox_q;
		oy_n     = oy_q;
		width_n  = width_q;
		height_n = height_q;
		wlr_n    = wlr_q;
		restart  = cfg_we;
		unique case (cfg_index)
			REG_ORIGIN_X:        ox_n     = cfg_data;
			REG_ORIGIN_Y:        oy_n     = cfg_data;
			REG_IMAGE_WIDTH:     width_n  = cfg_data;
			REG_IMAGE_HEIGHT:    height_n = cfg_data;
			REG_WINDOW_LAST_ROW: wlr_n    = cfg_data;
			default:             restart  = 1'b0;
		endcase
	end

	// negative origins clamp to zero for the base offset
	always_comb begin
		row0 = {{(ROW_W-8){oy_n[7]}}, oy_n};
		rb0  = (ox_n[7] ? '0 : OFFSET_W'(ox_n))
		     + (oy_n[7] ? '0 : OFFSET_W'(OFFSET_W'(oy_n) * ROW_STEP));
		fin0 = $signed(row0) > $signed({{(ROW_W-8){1'b0}}, wlr_n});
	end

	always_comb begin
		held_n   = held_q;
		run_n    = run_q;
		await_n  = await_q;
		col_n    = col_q;
		rows_n   = rows_q;
		row_n    = row_q;
		in_win_n = in_win_q;
		rb_n     = rb_q;
		wp_n     = wp_q;
		fin_n    = fin_q;
		do_emit  = 1'b0;
		tile_src = held_q;
		result   = '0;
		result.status = ST_TILE;

		col_pos  = {{(ROW_W-8){ox_q[7]}}, ox_q} + {{(ROW_W-8){1'b0}}, col_q};
		tile_we  = in_win_q && !col_pos[ROW_W-1] && ($signed(col_pos) < $signed(SCR_COLS_RW));
		col_inc  = col_q + 8'd1;
		rows_inc = rows_q + 8'd1;
		row_inc  = row_q + ROW_W'(1);

		if (fin_q) begin
			result.status = ST_FINISHED;
		end else if (item.req_type) begin
			if (await_q || run_q == 8'd0) begin
				result.status = ST_IDLE;
			end else begin
				run_n   = run_q - 8'd1;
				do_emit = 1'b1;
			end
		end else if (await_q) begin
			await_n = 1'b0;
			run_n   = item.stream_byte;
			do_emit = 1'b1;
		end else begin
			run_n    = 8'd0;
			held_n   = item.stream_byte;
			tile_src = item.stream_byte;
			if (item.stream_byte[7]) begin
				await_n       = 1'b1;
				result.status = ST_BYTE;
			end else begin
				do_emit = 1'b1;
			end
		end

		if (do_emit) begin
			result.write_enable  = tile_we;
			result.screen_offset = tile_we ? wp_q : '0;
			result.tile_value    = tile_src | TILE_MARK;
			if (tile_we)
				wp_n = wp_q + OFFSET_W'(1);
			if (col_inc == width_q) begin
				col_n  = 8'd0;
				row_n  = row_inc;
				rows_n = rows_inc;
				if (rows_inc == height_q) begin
					fin_n = 1'b1;
				end else if ($signed(row_inc) > $signed({{(ROW_W-8){1'b0}}, wlr_q})) begin
					fin_n = 1'b1;
				end else begin
					// first row at or below screen top enters the window
					if (!in_win_q) begin
						if (!row_inc[ROW_W-1])
							in_win_n = 1'b1;
					end else begin
						rb_n = rb_q + ROW_STEP;
					end
					wp_n = in_win_q ? rb_q + ROW_STEP : rb_q;
				end
				result.last = fin_n;
			end else begin
				col_n = col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q     <= 8'd0;
			oy_q     <= 8'd0;
			width_q  <= 8'd1;
			height_q <= 8'd1;
			wlr_q    <= 8'd0;
			held_q   <= 8'd0;
			run_q    <= 8'd0;
			await_q  <= 1'b0;
			col_q    <= 8'd0;
			rows_q   <= 8'd0;
			row_q    <= '0;
			in_win_q <= 1'b1;
			rb_q     <= '0;
			wp_q     <= '0;
			fin_q    <= 1'b0;
		end else if (restart) begin
			ox_q     <= ox_n;
			oy_q     <= oy_n;
			width_q  <= width_n;
			height_q <= height_n;
			wlr_q    <= wlr_n;
			held_q   <= 8'd0;
			run_q    <= 8'd0;
			await_q  <= 1'b0;
			col_q    <= 8'd0;
			rows_q   <= 8'd0;
			row_q    <= row0;
			in_win_q <= !fin0 && !row0[ROW_W-1];
			rb_q     <= rb0;
			wp_q     <= rb0;
			fin_q    <= fin0;
		end else if (accept) begin
			held_q   <= held_n;
			run_q    <= run_n;
			await_q  <= await_n;
			col_q    <= col_n;
			rows_q   <= rows_n;
			row_q    <= row_n;
			in_win_q <= in_win_n;
			rb_q     <= rb_n;
			wp_q     <= wp_n;
			fin_q    <= fin_n;
		end
	end

endmodule
`default_nettype wire

/* tb/rle_tile_decoder_with_clipping_tb.sv */
module rle_tile_decoder_with_clipping_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rletd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_GOAL   = 1650;

	class tile_scoreboard;
		logic [7:0]  org_x, org_y, img_w, img_h, last_row;
		logic [7:0]  held, run_left, col_idx, rows_done;
		bit          awaiting, in_win, done;
		int          cur_row;
		logic [15:0] row_base, wr_ptr;

		out_item_t expected_tiles[$];
		int mismatches, checked, tiles_written, images_done;

		function new();
			org_x = 8'd0;
			org_y = 8'd0;
			img_w = 8'd1;
			img_h = 8'd1;
			last_row = 8'd0;
			mismatches = 0;
			checked = 0;
			tiles_written = 0;
			images_done = 0;
			start_image();
		endfunction

		function void open_row();
			if (cur_row > int'(last_row)) begin
				done = 1'b1;
				return;
			end
			if (!in_win) begin
				if (cur_row >= 0)
					in_win = 1'b1;
			end else begin
				row_base = row_base + 16'(SCREEN_COLUMNS);
			end
			wr_ptr = row_base;
		endfunction

		function void start_image();
			held = 8'd0;
			run_left = 8'd0;
			awaiting = 1'b0;
			col_idx = 8'd0;
			rows_done = 8'd0;
			in_win = 1'b0;
			done = 1'b0;
			cur_row = int'($signed(org_y));
			row_base = 16'd0;
			if ($signed(org_x) > 0)
				row_base = row_base + 16'(org_x);
			if (cur_row > 0)
				row_base = row_base + 16'(cur_row * int'(SCREEN_COLUMNS));
			wr_ptr = row_base;
			open_row();
		endfunction

		function void write_reg(cfg_reg_e idx, logic [7:0] v);
			case (idx)
				REG_ORIGIN_X:        org_x = v;
				REG_ORIGIN_Y:        org_y = v;
				REG_IMAGE_WIDTH:     img_w = v;
				REG_IMAGE_HEIGHT:    img_h = v;
				REG_WINDOW_LAST_ROW: last_row = v;
				default:             return;
			endcase
			start_image();
		endfunction

		function out_item_t place_tile();
			out_item_t  r;
			int         col;
			bit         we;
			logic [7:0] nxt;
			r = '0;
			col = int'($signed(org_x)) + int'(col_idx);
			we = in_win && col >= 0 && col < int'(SCREEN_COLUMNS);
			r.status = ST_TILE;
			r.write_enable = we;
			r.screen_offset = we ? wr_ptr : 16'd0;
			r.tile_value = held | TILE_MARK;
			if (we) begin
				wr_ptr = wr_ptr + 16'd1;
				tiles_written++;
			end
			nxt = col_idx + 8'd1;
			// zero width or height wraps the 8-bit up-counter, giving 256
			if (nxt == img_w) begin
				col_idx = 8'd0;
				cur_row++;
				rows_done = rows_done + 8'd1;
				if (rows_done == img_h)
					done = 1'b1;
				else
					open_row();
				r.last = done;
				if (done)
					images_done++;
			end else begin
				col_idx = nxt;
			end
			return r;
		endfunction

		function void decode_item(in_item_t it);
			out_item_t r;
			r = '0;
			if (done) begin
				r.status = ST_FINISHED;
			end else if (it.req_type) begin
				if (awaiting || run_left == 8'd0) begin
					r.status = ST_IDLE;
				end else begin
					run_left = run_left - 8'd1;
					r = place_tile();
				end
			end else if (awaiting) begin
				awaiting = 1'b0;
				run_left = it.stream_byte;
				r = place_tile();
			end else begin
				// a fresh byte drops whatever is left of a run
				run_left = 8'd0;
				held = it.stream_byte;
				if (held[7]) begin
					awaiting = 1'b1;
					r.status = ST_BYTE;
				end else begin
					r = place_tile();
				end
			end
			expected_tiles.push_back(r);
		endfunction

		function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t MISMATCH %s: expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void compare_tile(out_item_t got);
			out_item_t want;
			if (expected_tiles.size() == 0) begin
				note_mismatch("unexpected result, status", 16'd0, 16'(got.status));
				return;
			end
			want = expected_tiles.pop_front();
			checked++;
			if (got.status !== want.status)
				note_mismatch("status", 16'(want.status), 16'(got.status));
			if (got.write_enable !== want.write_enable)
				note_mismatch("write_enable", 16'(want.write_enable), 16'(got.write_enable));
			if (got.screen_offset !== want.screen_offset)
				note_mismatch("screen_offset", want.screen_offset, got.screen_offset);
			if (got.tile_value !== want.tile_value)
				note_mismatch("tile_value", 16'(want.tile_value), 16'(got.tile_value));
			if (got.last !== want.last)
				note_mismatch("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	tile_scoreboard sb = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int holdoff = 0;
	int useful_items = 0;
	int settings = 0;

	rle_tile_decoder_with_clipping uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT,
			sb.expected_tiles.size());
		$display("Test completed with failures");
		$finish;
	end

	// receiver: check each output transfer, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.compare_tile(out_data);
		if (holdoff > 0) begin
			out_stall <= 1'b1;
			holdoff--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic push_item(logic req, logic [7:0] b);
		in_item_t it;
		int gap;
		it.req_type = req;
		it.stream_byte = b;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!sb.done)
			useful_items++;
		sb.decode_item(it);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_tiles.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_e idx, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic configure(logic [7:0] ox, logic [7:0] oy, logic [7:0] w, logic [7:0] h,
			logic [7:0] lr);
		put_reg(REG_ORIGIN_X, ox);
		put_reg(REG_ORIGIN_Y, oy);
		put_reg(REG_IMAGE_WIDTH, w);
		put_reg(REG_IMAGE_HEIGHT, h);
		put_reg(REG_WINDOW_LAST_ROW, lr);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [7:0] pick_of(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		case ($urandom_range(3))
			0:       return a;
			1:       return b;
			2:       return c;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic run_phase(int target, int run_cap, bit pause_mid);
		int sent, pick, cnt, reps;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < target && !sb.done) begin
			if (pause_mid && !paused && sent >= target / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.expected_tiles.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				push_item(1'b0, 8'($urandom_range(127)));
				sent++;
			end else if (pick < 85) begin
				// marked byte, count, then repeat requests, at times fewer or more than the run
				cnt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
				push_item(1'b0, 8'($urandom_range(255, 128)));
				push_item(1'b0, 8'(cnt));
				sent += 2;
				reps = cnt;
				case ($urandom_range(9))
					0:       reps = $urandom_range(cnt);
					1:       reps = cnt + 1 + $urandom_range(2);
					default: reps = cnt;
				endcase
				if (reps > run_cap)
					reps = run_cap;
				for (int k = 0; k < reps && !sb.done; k++) begin
					push_item(1'b1, 8'($urandom_range(255)));
					sent++;
				end
			end else if (pick < 93) begin
				push_item(1'b1, 8'($urandom_range(255)));
				sent++;
			end else begin
				// broken pair: marked byte answered by a repeat request
				push_item(1'b0, 8'($urandom_range(255, 128)));
				push_item(1'b1, 8'($urandom_range(255)));
				sent += 2;
			end
		end
		if (sb.done)
			repeat ($urandom_range(2))
				push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	initial begin
		int phase;
		logic [7:0] ox, oy, w, h, lr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: 1x1 image at the origin
		push_item(1'b1, 8'h00);
		push_item(1'b0, 8'h00);
		push_item(1'b0, 8'h7F);
		drain();

		// 4x3 image starting above and left of the window
		configure(8'hFE, 8'hFF, 8'd4, 8'd3, 8'd1);
		push_item(1'b0, 8'h7F);
		push_item(1'b0, 8'hFF);
		push_item(1'b1, 8'hFF);
		push_item(1'b0, 8'h00);
		push_item(1'b1, 8'h00);
		push_item(1'b0, 8'h85);
		push_item(1'b0, 8'h03);
		push_item(1'b1, 8'h5A);
		push_item(1'b0, 8'h12);
		push_item(1'b1, 8'hA5);
		push_item(1'b0, 8'h80);
		push_item(1'b0, 8'hFF);
		repeat (7) push_item(1'b1, 8'h00);
		push_item(1'b0, 8'h00);
		drain();

		phase = 1;
		while (useful_items < ITEM_GOAL) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 76; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 76; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			if (phase % 5 == 4) begin
				ox = pick_of(8'h80, 8'h7F, 8'h00);
				oy = pick_of(8'h80, 8'h7F, 8'h00);
				w  = pick_of(8'd0, 8'd1, 8'd255);
				h  = pick_of(8'd0, 8'd1, 8'd255);
				lr = pick_of(8'd0, 8'd255, 8'd2);
			end else begin
				ox = 8'(int'($urandom_range(72)) - 40);
				oy = 8'(int'($urandom_range(10)) - 5);
				w  = ($urandom_range(7) == 0) ? 8'($urandom_range(40, 13)) :
					8'($urandom_range(12, 1));
				h  = 8'($urandom_range(4, 1));
				lr = 8'($urandom_range(8));
			end
			configure(ox, oy, w, h, lr);
			// long receiver hold-off while the sender keeps offering
			if (phase % 8 == 0)
				holdoff = 40 + $urandom_range(20);
			run_phase($urandom_range(60, 20), (phase % 5 == 4) ? 300 : 24, phase % 4 == 2);
			drain();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (sb.expected_tiles.size() != 0)
			sb.note_mismatch("results never arrived", 16'd0, 16'(sb.expected_tiles.size()));
		$display("Fed %0d decoding items across %0d register settings; %0d results checked.",
			useful_items, settings, sb.checked);
		$display("Tiles written %0d, images completed %0d, mismatches %0d.",
			sb.tiles_written, sb.images_done, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/core/rletd_pkg.sv
rtl/core/rletd_skid.sv
rtl/core/rletd_core.sv
rtl/core/rle_tile_decoder_with_clipping.sv
tb/rle_tile_decoder_with_clipping_tb.sv
